[sv/sequential_list_engine_assert.svh]
`ifndef SEQUENTIAL_LIST_ENGINE_ASSERT_SVH
`define SEQUENTIAL_LIST_ENGINE_ASSERT_SVH

// same-cycle implication, sampled on clk, off during rst
`define SLE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, sampled on clk, off during rst
`define SLE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[sv/sle_pkg.sv]
package sle_pkg;

  localparam int CAPACITY = 64;
  localparam int ELEM_W   = 32;
  localparam int AW       = $clog2(CAPACITY);
  localparam int CW       = 7;

  typedef enum logic [2:0] {
    REQ_INSERT = 3'd0,
    REQ_REMOVE = 3'd1,
    REQ_SEARCH = 3'd2,
    REQ_GET    = 3'd3,
    REQ_SET    = 3'd4
  } req_kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic [2:0]        req_type;
    logic [CW-1:0]     position;
    logic [ELEM_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic              ok;
    logic [CW-1:0]     found_position;
    logic [ELEM_W-1:0] read_value;
    logic [CW-1:0]     list_length;
  } rsp_t;

  typedef struct packed {
    logic          ok;
    logic [AW-1:0] rd_start;
    logic [CW-1:0] rd_count;
    logic          rd_up;
    logic          final_write;
    logic [AW-1:0] final_addr;
    logic [CW-1:0] count_next;
  } plan_t;

endpackage

[sv/sequential_list_engine.sv]
// Requests are handled one at a time: req_stall is high outside idle. Store reads per request:
// entries from the position to the end for insert and remove, the list length for search,
// one for get, none for set or a refused request. The element store has a single read port
// and a single write port. Reset: rst clears the length count, sequencer and response valid;
// store contents stay, only entries below length are read.
module sequential_list_engine
  import sle_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

  state_t            state, state_next;
  plan_t             plan_in, plan;
  logic [2:0]        kind;
  logic [AW-1:0]     pos_m1;
  logic [ELEM_W-1:0] val;
  logic [CW-1:0]     count;
  logic [AW-1:0]     rd_addr;
  logic [CW-1:0]     rd_remain;
  logic              pend;
  logic [AW-1:0]     pend_addr;
  logic [CW-1:0]     found;
  logic [ELEM_W-1:0] rdval;

  logic [ELEM_W-1:0] mem [CAPACITY];
  logic [ELEM_W-1:0] mem_rdata;
  logic              mem_re, mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [ELEM_W-1:0] mem_wdata;

  logic              accept, run_done, fin_go;

  sle_check u_check (
    .req   (req),
    .count (count),
    .plan  (plan_in)
  );

  assign req_stall = (state != ST_IDLE);
  assign accept    = req_valid && !req_stall;
  assign run_done  = (rd_remain == '0) && !pend;
  assign fin_go    = (state == ST_FINISH) && (!rsp_valid || !rsp_stall);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (req_valid) state_next = ST_RUN;
      ST_RUN:    if (run_done) state_next = ST_FINISH;
      ST_FINISH: if (!rsp_valid || !rsp_stall) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    mem_re    = (state == ST_RUN) && (rd_remain != '0);
    mem_we    = 1'b0;
    mem_waddr = pend_addr;
    mem_wdata = mem_rdata;
    unique case (state)
      ST_RUN: begin
        if (pend && (kind == REQ_INSERT)) begin
          mem_we    = 1'b1;
          mem_waddr = pend_addr + AW'(1);
        end else if (pend && (kind == REQ_REMOVE) && (pend_addr != pos_m1)) begin
          mem_we    = 1'b1;
          mem_waddr = pend_addr - AW'(1);
        end
      end
      ST_FINISH: begin
        if (fin_go && plan.final_write) begin
          mem_we    = 1'b1;
          mem_waddr = plan.final_addr;
          mem_wdata = val;
        end
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      rsp_valid <= 1'b0;
      pend      <= 1'b0;
      rd_remain <= '0;
    end else begin
      state <= state_next;
      pend  <= mem_re;
      if (accept) begin
        rd_remain <= plan_in.rd_count;
      end else if (mem_re) begin
        rd_remain <= rd_remain - CW'(1);
      end
      if (fin_go) begin
        count     <= plan.count_next;
        rsp_valid <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      kind    <= req.req_type;
      pos_m1  <= AW'(req.position - CW'(1));
      val     <= req.value;
      plan    <= plan_in;
      rd_addr <= plan_in.rd_start;
      found   <= '0;
      rdval   <= '0;
    end else begin
      if (mem_re) begin
        rd_addr <= plan.rd_up ? rd_addr + AW'(1) : rd_addr - AW'(1);
      end
      if (pend) begin
        if ((kind == REQ_SEARCH) && (found == '0) && (mem_rdata == val)) begin
          found <= CW'(pend_addr) + CW'(1);
        end
        if ((kind == REQ_GET) || ((kind == REQ_REMOVE) && (pend_addr == pos_m1))) begin
          rdval <= mem_rdata;
        end
      end
    end
    pend_addr <= rd_addr;
    if (fin_go) begin
      rsp.ok             <= plan.ok;
      rsp.found_position <= found;
      rsp.read_value     <= rdval;
      rsp.list_length    <= plan.count_next;
    end
  end

`include "sequential_list_engine_assert.svh"

  `SLE_ASSERT_NOW(a_count_cap, 1'b1, count <= CW'(CAPACITY), "list length above capacity")
  `SLE_ASSERT_NEXT(a_count_hold, state != ST_FINISH, $stable(count), "length moved mid-request")
  `SLE_ASSERT_NEXT(a_run_end, (state == ST_RUN) && run_done, state == ST_FINISH,
                   "sequencer missed finish")

endmodule

[sv/sle_check.sv]
module sle_check
  import sle_pkg::*;
(
  input  req_t          req,
  input  logic [CW-1:0] count,
  output plan_t         plan
);

  logic          in_range;
  logic [CW-1:0] pos_m1;

  assign in_range = (req.position != '0) && (req.position <= count);
  assign pos_m1   = req.position - CW'(1);

  always_comb begin
    plan             = '0;
    plan.count_next  = count;
    plan.rd_start    = AW'(pos_m1);
    plan.final_addr  = AW'(pos_m1);
    unique case (req.req_type)
      REQ_INSERT: begin
        if ((count < CW'(CAPACITY)) && (req.position <= count)) begin
          plan.ok          = 1'b1;
          plan.rd_start    = AW'(count - CW'(1));
          plan.rd_count    = count - req.position;
          plan.rd_up       = 1'b0;
          plan.final_write = 1'b1;
          plan.final_addr  = AW'(req.position);
          plan.count_next  = count + CW'(1);
        end
      end
      REQ_REMOVE: begin
        if (in_range) begin
          plan.ok         = 1'b1;
          plan.rd_count   = count - pos_m1;
          plan.rd_up      = 1'b1;
          plan.count_next = count - CW'(1);
        end
      end
      REQ_SEARCH: begin
        plan.ok       = 1'b1;
        plan.rd_start = '0;
        plan.rd_count = count;
        plan.rd_up    = 1'b1;
      end
      REQ_GET: begin
        if (in_range) begin
          plan.ok       = 1'b1;
          plan.rd_count = CW'(1);
          plan.rd_up    = 1'b1;
        end
      end
      REQ_SET: begin
        if (in_range) begin
          plan.ok          = 1'b1;
          plan.final_write = 1'b1;
        end
      end
      default: begin
        plan.ok = 1'b0;
      end
    endcase
  end

endmodule
